/* sv/stereo_linear_resampler_macros.svh */
// Assertion macros for the resampler checker.
`ifndef STEREO_LINEAR_RESAMPLER_MACROS_SVH
`define STEREO_LINEAR_RESAMPLER_MACROS_SVH

// Implication into the next cycle, off while reset is high.
`define SLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// Implication into the next cycle, also checked across reset.
`define SLR_ASSERT_NEXT_ALL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// Same-cycle implication, off while reset is high.
`define SLR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`endif

/* sv/slr_pkg.sv */
// Shared constants for the stereo linear resampler.
`default_nettype none

package slr_pkg;

  // Sample and field widths
  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 12;
  localparam int STEP_W   = 28;

  // Fixed-point position format
  localparam int FRAC_BITS    = 24;
  localparam int BLOCK_FRAMES = 128;
  localparam int FRAME_W      = $clog2(BLOCK_FRAMES);
  // integer range of one step
  localparam int STEP_INT     = 1 << (STEP_W - FRAC_BITS);
  localparam int IDX_W        = $clog2(BLOCK_FRAMES + STEP_INT - 1);
  localparam int POS_W        = IDX_W + FRAC_BITS;

  // Step floor of 1/16
  localparam int MIN_STEP_LOG2 = 4;
  localparam logic [STEP_W-1:0] MIN_STEP   = STEP_W'(1) << (FRAC_BITS - MIN_STEP_LOG2);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1) << FRAC_BITS;

  // Results per item
  localparam int MAX_RESULTS = 32;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  // Digit-serial multiplier
  localparam int DIGIT_W = 4;
  localparam int DIGITS  = FRAC_BITS / DIGIT_W;
  localparam int LCNT_W  = $clog2(DIGITS + 1);

  // Register port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_STEP = '0;

endpackage

`default_nettype wire

/* sv/slr_lerp.sv */
// Digit-serial linear interpolation of one channel, truncated toward zero.
`default_nettype none

module slr_lerp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [slr_pkg::FRAC_BITS-1:0]      frac,
  input  logic signed [slr_pkg::SAMPLE_W-1:0] s1,
  input  logic signed [slr_pkg::SAMPLE_W-1:0] s2,
  output logic                               done,
  output logic signed [slr_pkg::SAMPLE_W-1:0] result
);
  import slr_pkg::*;

  logic [FRAC_BITS-1:0]                 frac_sr;
  logic signed [SAMPLE_W:0]             diff;
  logic signed [SAMPLE_W-1:0]           base;
  logic signed [SAMPLE_W+1:0]           hi;
  logic                                 sticky;
  logic [LCNT_W-1:0]                    cnt;
  logic                                 busy;
  logic signed [SAMPLE_W+DIGIT_W+1:0]   prod;
  logic signed [SAMPLE_W+DIGIT_W+1:0]   sum;
  logic signed [SAMPLE_W+2:0]           tot;
  logic signed [SAMPLE_W+2:0]           rounded;

  // One fraction digit times the difference, added to the running high part
  assign prod = $signed({1'b0, frac_sr[DIGIT_W-1:0]}) * diff;
  assign sum  = {{DIGIT_W{hi[SAMPLE_W+1]}}, hi} + prod;

  // Add s1, then step a negative value with dropped bits up toward zero
  assign tot     = {hi[SAMPLE_W+1], hi} + {{3{base[SAMPLE_W-1]}}, base};
  assign rounded = tot + {{(SAMPLE_W+2){1'b0}}, (tot[SAMPLE_W+2] & sticky)};
  assign result  = rounded[SAMPLE_W-1:0];

  // Sequencer: low digit first, product shifts right one digit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // pulse after the last digit
      done <= !start && busy && (cnt == LCNT_W'(1));
      if (start) begin
        frac_sr <= frac;
        diff    <= {s2[SAMPLE_W-1], s2} - {s1[SAMPLE_W-1], s1};
        base    <= s1;
        hi      <= '0;
        sticky  <= 1'b0;
        cnt     <= LCNT_W'(DIGITS);
        busy    <= 1'b1;
      end else if (busy) begin
        hi      <= sum[SAMPLE_W+DIGIT_W+1:DIGIT_W];
        sticky  <= sticky | (|sum[DIGIT_W-1:0]);
        frac_sr <= frac_sr >> DIGIT_W;
        cnt     <= cnt - LCNT_W'(1);
        if (cnt == LCNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* sv/stereo_linear_resampler.sv */
// Stereo linear-interpolation resampler, top level.
// Input channel: one stereo frame per item (in_valid / in_stall). Frames of a
// block follow each other; last_in_block or the 128th frame closes the block,
// and out_count is taken from the block's first frame.
// Output channel: resampled frames (out_valid / out_stall), with last_of_run
// on the final result of an input item and block_done on the block's final one.
// Register port: step_ratio at byte address 0, input/output rate with 24
// fraction bits; writes must land between items (not enforced by the block).
// Flow: the block takes one item at a time. Each interpolated result runs
// through the 4-bit-per-cycle serial multiplier (6 digits plus load and
// hand-off); a held result on the last frame needs no multiply. A stalled
// receiver lengthens the item.
// The final result of an item sits in the output register while the next
// item is taken in. A stalled receiver holds the output and, once the next
// result is ready, holds the block too.
// Reset: synchronous; clears the block state, sets step_ratio to 1.0 and
// drops any result in flight.
`default_nettype none

module stereo_linear_resampler (
  input  logic                                clk,
  input  logic                                rst,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [slr_pkg::PADDR_W-1:0]         paddr,
  input  logic [slr_pkg::PDATA_W-1:0]         pwdata,
  output logic [slr_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  // input frames
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [slr_pkg::SAMPLE_W-1:0] left_sample,
  input  logic signed [slr_pkg::SAMPLE_W-1:0] right_sample,
  input  logic                                last_in_block,
  input  logic [slr_pkg::CNT_W-1:0]           out_count,
  // output frames
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [slr_pkg::SAMPLE_W-1:0] out_left,
  output logic signed [slr_pkg::SAMPLE_W-1:0] out_right,
  output logic                                last_of_run,
  output logic                                block_done
);
  import slr_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_MUL} state_t;

  state_t                     state;
  logic [STEP_W-1:0]          step_ratio;
  logic [FRAME_W-1:0]         frame_index;
  logic [CNT_W-1:0]           out_index;
  logic [CNT_W-1:0]           block_out_count;
  logic [POS_W-1:0]           position;
  logic [RES_W-1:0]           n_res;
  logic signed [SAMPLE_W-1:0] cur_l, cur_r, prev_l, prev_r;
  logic signed [SAMPLE_W-1:0] pend_l, pend_r;
  logic                       pend_done;
  logic                       have_pending;
  logic                       last_r;

  logic                       reg_wr;
  logic                       reg_sel;
  logic [STEP_W-1:0]          step_eff;
  logic [IDX_W-1:0]           idx;
  logic [IDX_W-1:0]           k_ext;
  logic                       is_lerp, is_hold, emit;
  logic                       out_free, proceed;
  logic                       lerp_start;
  logic                       done_l, done_r;
  logic signed [SAMPLE_W-1:0] res_l, res_r;

  // Register port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_STEP);
  assign reg_wr  = psel & penable & pwrite & pready & reg_sel;
  assign prdata  = reg_sel ? PDATA_W'(step_ratio) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio <= STEP_RESET;
    end else if (reg_wr) begin
      step_ratio <= pwdata[STEP_W-1:0];
    end
  end

  // Next-result decision
  assign step_eff = (step_ratio < MIN_STEP) ? MIN_STEP : step_ratio;
  assign idx      = position[POS_W-1:FRAC_BITS];
  assign k_ext    = IDX_W'(frame_index);
  assign is_lerp  = (frame_index != '0) && (idx == k_ext - IDX_W'(1));
  assign is_hold  = last_r && (idx == k_ext);
  assign emit     = (n_res < RES_W'(MAX_RESULTS)) && (out_index < block_out_count)
                    && (is_lerp || is_hold);

  // A pending result leaves only when the output register can take it
  assign out_free   = !out_valid || !out_stall;
  assign proceed    = (state == ST_EVAL) && (!have_pending || out_free);
  assign lerp_start = proceed && emit && is_lerp;
  assign in_stall   = (state != ST_IDLE);

  // Interpolation units, one per channel
  slr_lerp u_lerp_l (
    .clk    (clk),
    .rst    (rst),
    .start  (lerp_start),
    .frac   (position[FRAC_BITS-1:0]),
    .s1     (prev_l),
    .s2     (cur_l),
    .done   (done_l),
    .result (res_l)
  );

  slr_lerp u_lerp_r (
    .clk    (clk),
    .rst    (rst),
    .start  (lerp_start),
    .frac   (position[FRAC_BITS-1:0]),
    .s1     (prev_r),
    .s2     (cur_r),
    .done   (done_r),
    .result (res_r)
  );

  // Control sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      frame_index     <= '0;
      out_index       <= '0;
      block_out_count <= '0;
      position        <= '0;
      prev_l          <= '0;
      prev_r          <= '0;
      have_pending    <= 1'b0;
      out_valid       <= 1'b0;
      n_res           <= '0;
    end else begin
      // output register empties once taken, unless refilled this cycle
      if (out_valid && !out_stall && !(proceed && have_pending)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cur_l  <= left_sample;
            cur_r  <= right_sample;
            last_r <= last_in_block || (frame_index >= FRAME_W'(BLOCK_FRAMES - 1));
            n_res  <= '0;
            if (frame_index == '0) begin
              block_out_count <= out_count;
              out_index       <= '0;
              position        <= '0;
            end
            state <= ST_EVAL;
          end
        end

        ST_EVAL: begin
          if (proceed) begin
            // release the previous result, flagged if nothing follows it
            if (have_pending) begin
              out_valid   <= 1'b1;
              out_left    <= pend_l;
              out_right   <= pend_r;
              last_of_run <= !emit;
              block_done  <= pend_done || (!emit && last_r);
            end

            if (emit) begin
              out_index <= out_index + CNT_W'(1);
              position  <= position + POS_W'(step_eff);
              n_res     <= n_res + RES_W'(1);
              pend_done <= (out_index + CNT_W'(1) == block_out_count);
              if (is_lerp) begin
                have_pending <= 1'b0;
                state        <= ST_MUL;
              end else begin
                // hold the block's last frame
                pend_l       <= cur_l;
                pend_r       <= cur_r;
                have_pending <= 1'b1;
              end
            end else begin
              // item finished
              have_pending <= 1'b0;
              prev_l       <= cur_l;
              prev_r       <= cur_r;
              if (last_r) begin
                frame_index <= '0;
                out_index   <= '0;
                position    <= '0;
              end else begin
                frame_index <= frame_index + FRAME_W'(1);
              end
              state <= ST_IDLE;
            end
          end
        end

        ST_MUL: begin
          if (done_l && done_r) begin
            pend_l       <= res_l;
            pend_r       <= res_r;
            have_pending <= 1'b1;
            state        <= ST_EVAL;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/slr_checker.sv */
// Port-level checker for the resampler, bound to the top level.
`default_nettype none
`include "stereo_linear_resampler_macros.svh"

module slr_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [slr_pkg::SAMPLE_W-1:0] out_left,
  input  logic signed [slr_pkg::SAMPLE_W-1:0] out_right,
  input  logic                                last_of_run,
  input  logic                                block_done
);

  // Reset empties the output and leaves the block ready
  `SLR_ASSERT_NEXT_ALL(a_reset_clears, rst, !out_valid && !in_stall)

  // An accepted item makes the block stall its input in the next cycle
  `SLR_ASSERT_NEXT(a_item_busy, in_valid && !in_stall, in_stall)

  // The block's final result always closes its item's run
  `SLR_ASSERT_NOW(a_done_ends_run, out_valid && block_done, last_of_run)

  // A stalled result is held
  `SLR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_left) && $stable(out_right) &&
    $stable(last_of_run) && $stable(block_done))

endmodule

bind stereo_linear_resampler slr_checker u_slr_checker (.*);

`default_nettype wire
